### rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, constants and widths of the Bezier curve sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int MaxPointsDefault  = 16;
  localparam int MaxSamplesDefault = 64;
  localparam int FracBitsDefault   = 16;

  localparam int CoordW  = 32;
  localparam int CountW  = 7;
  localparam int IndexW  = 6;

  localparam logic [CountW-1:0] SampleCountReset = 7'd16;

  // Configuration register indexes.
  localparam int RegSampleCount = 0;

  // Datapath command and status between controller and datapath.
  typedef struct packed {
    logic store;      // write the input point at the fill count
    logic t_start;    // begin the t division for the current sample
    logic w_init;     // load the weight vector with B(0,0)
    logic w_step;     // one Bernstein recurrence step for order m
    logic acc_clr;    // clear the coordinate accumulators
    logic acc_step;   // multiply-accumulate the term selected by the term index
    logic out_load;   // round, saturate and present the result
  } bcs_cmd_t;

  typedef struct packed {
    logic t_done;
    logic rd_valid;
  } bcs_stat_t;

endpackage

### rtl/bcs_if.sv
// ----------------------------------------------------------------------------
// bcs_in_if / bcs_out_if
// Valid/ready channels that carry control points and curve samples.
// ----------------------------------------------------------------------------
interface bcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               final_point;
  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface bcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic signed [31:0] curve_z;
  logic [5:0]         sample_index;
  logic               final_sample;
  logic               points_dropped;
  modport source (output valid, curve_x, curve_y, curve_z, sample_index, final_sample,
                  points_dropped, input ready);
  modport sink   (input valid, curve_x, curve_y, curve_z, sample_index, final_sample,
                  points_dropped, output ready);
endinterface

### rtl/bcs_datapath.sv
// ----------------------------------------------------------------------------
// bcs_datapath
// Point store, serial t divider, Bernstein weight unit and a
// multiply-accumulate for each of the three coordinates.
// ----------------------------------------------------------------------------
module bcs_datapath #(
  parameter int MAX_POINTS  = bcs_pkg::MaxPointsDefault,
  parameter int FRAC_BITS   = bcs_pkg::FracBitsDefault,
  localparam int PtrW = $clog2(MAX_POINTS + 1),
  localparam int AdrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bcs_pkg::bcs_cmd_t          cmd,
  output bcs_pkg::bcs_stat_t         stat,
  input  logic [PtrW-1:0]            fill,       // store address for writes
  input  logic [AdrW-1:0]            term,       // weight index for step / MAC
  input  logic [AdrW-1:0]            order,      // m for recurrence
  input  logic [bcs_pkg::IndexW-1:0] sample,
  input  logic [bcs_pkg::CountW-1:0] span,       // S-1
  input  logic signed [31:0]         in_x,
  input  logic signed [31:0]         in_y,
  input  logic signed [31:0]         in_z,
  output logic signed [31:0]         res_x,
  output logic signed [31:0]         res_y,
  output logic signed [31:0]         res_z
);
  localparam int WW   = FRAC_BITS + 1;
  localparam int NumW = bcs_pkg::IndexW + FRAC_BITS;
  localparam int AccW = 32 + WW + PtrW + 1;
  localparam logic [WW-1:0] One = WW'(1) << FRAC_BITS;
  localparam logic [2*WW:0] Half = (2*WW+1)'(1) << (FRAC_BITS - 1);

  logic [95:0] mem [MAX_POINTS];
  logic [95:0] rd_data;
  logic        rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill[AdrW-1:0]] <= {in_x, in_y, in_z};
    end
    rd_data <= mem[term];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.acc_step;
    end
  end

  // Restoring divider: t = (i*2^F + span/2) / span, one quotient bit a cycle.
  logic [NumW-1:0]   num;
  logic [NumW-1:0]   quo;
  logic [bcs_pkg::CountW:0] rem;
  logic [$clog2(NumW+1)-1:0] bits_left;
  logic              busy;
  logic [bcs_pkg::CountW:0] rem_sh;

  assign rem_sh = {rem[bcs_pkg::CountW-1:0], num[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.t_start) begin
      busy <= 1'b1;
    end else if (busy && bits_left == 1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.t_start) begin
      num       <= ({sample, FRAC_BITS'(0)}) + NumW'(span >> 1);
      quo       <= '0;
      rem       <= '0;
      bits_left <= ($clog2(NumW+1))'(NumW);
    end else if (busy) begin
      num       <= num << 1;
      bits_left <= bits_left - 1'b1;
      if (rem_sh >= {1'b0, span}) begin
        rem <= rem_sh - {1'b0, span};
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NumW-2:0], 1'b0};
      end
    end
  end

  assign stat.t_done   = !busy && !cmd.t_start;
  assign stat.rd_valid = rd_valid;

  logic [WW-1:0] t_val;
  logic [WW-1:0] omt;
  assign t_val = (quo > NumW'(One)) ? One : quo[WW-1:0];
  assign omt   = One - t_val;

  // Weight vector; one recurrence step per cycle, k from m down to 0.
  logic [WW-1:0] w [MAX_POINTS];
  logic [WW-1:0] w_lo;
  logic [WW-1:0] w_hi;
  logic [2*WW:0] w_sum;

  assign w_hi  = (term == order) ? '0 : w[term];
  assign w_lo  = (term == '0) ? '0 : w[term - 1'b1];
  assign w_sum = {{(WW+1){1'b0}}, omt} * {{(WW+1){1'b0}}, w_hi}
               + {{(WW+1){1'b0}}, t_val} * {{(WW+1){1'b0}}, w_lo} + Half;

  always_ff @(posedge clk) begin
    if (cmd.w_init) begin
      w[0] <= One;
    end else if (cmd.w_step) begin
      w[term] <= w_sum[FRAC_BITS +: WW];
    end
  end

  // Term MAC: register the weight alongside the read data, then accumulate.
  logic [WW-1:0] w_rd;
  logic signed [AccW-1:0] acc_x, acc_y, acc_z;
  logic signed [WW:0] ws;

  always_ff @(posedge clk) begin
    w_rd <= w[term];
  end
  assign ws = signed'({1'b0, w_rd});

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (rd_valid) begin
      acc_x <= acc_x + AccW'(ws) * AccW'(signed'(rd_data[95:64]));
      acc_y <= acc_y + AccW'(ws) * AccW'(signed'(rd_data[63:32]));
      acc_z <= acc_z + AccW'(ws) * AccW'(signed'(rd_data[31:0]));
    end
  end

  function automatic logic signed [31:0] round_sat(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] r;
    r = (a + AccW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > AccW'(32'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (r < -AccW'(64'sh80000000)) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_x <= round_sat(acc_x);
      res_y <= round_sat(acc_y);
      res_z <= round_sat(acc_z);
    end
  end

endmodule

### rtl/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// bcs_ctrl
// Sequencer: collects points, then walks samples, recurrence orders, terms.
// ----------------------------------------------------------------------------
module bcs_ctrl #(
  parameter int MAX_POINTS  = bcs_pkg::MaxPointsDefault,
  parameter int MAX_SAMPLES = bcs_pkg::MaxSamplesDefault,
  localparam int PtrW = $clog2(MAX_POINTS + 1),
  localparam int AdrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_final,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bcs_pkg::IndexW-1:0] out_index,
  output logic                       out_last,
  output logic                       out_dropped,
  input  logic [bcs_pkg::CountW-1:0] sample_count,
  output bcs_pkg::bcs_cmd_t          cmd,
  input  bcs_pkg::bcs_stat_t         stat,
  output logic [PtrW-1:0]            fill,
  output logic [AdrW-1:0]            term,
  output logic [AdrW-1:0]            order,
  output logic [bcs_pkg::IndexW-1:0] t_sample,
  output logic [bcs_pkg::CountW-1:0] span
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_REC  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [2:0] state, state_next;
  logic       dropped;
  logic [AdrW-1:0] last_term;
  logic       in_xfer;
  logic [bcs_pkg::IndexW-1:0] sample;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = (state == S_LOAD);
  assign last_term = AdrW'(fill - 1'b1);

  // The divider loads on the same edge that advances the sample, so it is
  // handed the index of the sample that comes next.
  assign t_sample = (state == S_HOLD) ? sample + 1'b1 : sample;

  always_comb begin
    if (sample_count < 7'd2) begin
      span = 7'd1;
    end else if (sample_count > 7'(MAX_SAMPLES)) begin
      span = 7'(MAX_SAMPLES - 1);
    end else begin
      span = sample_count - 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.store    = in_xfer && (fill < PtrW'(MAX_POINTS));
    cmd.t_start  = in_xfer && in_final;
    cmd.w_init   = (state == S_DIV) && stat.t_done;
    cmd.acc_clr  = (state == S_DIV) && stat.t_done;
    cmd.w_step   = (state == S_REC);
    cmd.acc_step = (state == S_MAC);
    cmd.out_load = (state == S_WAIT) && !stat.rd_valid;
    // Restart the divider for the following sample once this one is taken.
    if (state == S_HOLD && out_ready && {1'b0, sample} != span) begin
      cmd.t_start = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (in_xfer && in_final) state_next = S_DIV;
      S_DIV:  if (stat.t_done) state_next = (last_term == '0) ? S_MAC : S_REC;
      S_REC:  if (term == '0 && order == last_term) state_next = S_MAC;
      S_MAC:  if (term == last_term) state_next = S_WAIT;
      S_WAIT: if (!stat.rd_valid) state_next = S_OUT;
      S_OUT:  state_next = S_HOLD;
      S_HOLD: if (out_ready) state_next = ({1'b0, sample} == span) ? S_LOAD : S_DIV;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      fill    <= '0;
      dropped <= 1'b0;
      sample  <= '0;
      term    <= '0;
      order   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (fill < PtrW'(MAX_POINTS)) begin
              fill <= fill + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
          sample <= '0;
        end
        S_DIV: begin
          term  <= (last_term == '0) ? '0 : AdrW'(1);
          order <= AdrW'(1);
        end
        S_REC: begin
          if (term == '0) begin
            if (order == last_term) begin
              term <= '0;
            end else begin
              order <= order + 1'b1;
              term  <= order + 1'b1;
            end
          end else begin
            term <= term - 1'b1;
          end
        end
        S_MAC: if (term != last_term) term <= term + 1'b1;
        S_HOLD: begin
          if (out_ready) begin
            if ({1'b0, sample} == span) begin
              fill    <= '0;
              dropped <= 1'b0;
              sample  <= '0;
            end else begin
              sample <= sample + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == S_HOLD);
  assign out_index   = sample;
  assign out_last    = ({1'b0, sample} == span);
  assign out_dropped = dropped;

  ap_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ready) else $error("input taken while evaluating");
  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PtrW'(MAX_POINTS)) else $error("fill count beyond capacity");
  ap_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (fill != '0)) else $error("evaluating an empty curve");
  ap_index_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, sample} <= span)) else $error("sample index past end");

endmodule

### rtl/bezier_curve_sampler.sv
// Sequence: for a curve of P points (P <= MAX_POINTS), each sample runs the
// serial t divider, the Bernstein recurrence steps and the term MACs, then
// one output transfer; points are taken one per cycle while loading them.
// Throughput is bounded by the single shared weight/MAC unit per sample.
// Reset (rst, synchronous) empties the point store count, clears the drop flag
// and sets sample_count to 16; point store contents are not cleared.
// ----------------------------------------------------------------------------
// bezier_curve_sampler
// Bernstein-form Bezier curve evaluation over stored control points.
// ----------------------------------------------------------------------------
module bezier_curve_sampler #(
  parameter int MAX_POINTS  = bcs_pkg::MaxPointsDefault,
  parameter int MAX_SAMPLES = bcs_pkg::MaxSamplesDefault,
  parameter int FRAC_BITS   = bcs_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  bcs_in_if.sink      pin,
  bcs_out_if.source   pout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PtrW = $clog2(MAX_POINTS + 1);
  localparam int AdrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [bcs_pkg::CountW-1:0] sample_count;
  bcs_pkg::bcs_cmd_t  cmd;
  bcs_pkg::bcs_stat_t stat;
  logic [PtrW-1:0] fill;
  logic [AdrW-1:0] term, order;
  logic [bcs_pkg::IndexW-1:0] t_sample;
  logic [bcs_pkg::CountW-1:0] span;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= bcs_pkg::SampleCountReset;
    end else if (psel && penable && pwrite && paddr == 2'(bcs_pkg::RegSampleCount)) begin
      sample_count <= pwdata[bcs_pkg::CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == 2'(bcs_pkg::RegSampleCount)) begin
      prdata = 32'(sample_count);
    end
  end

  bcs_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk, .rst,
    .in_valid(pin.valid), .in_ready(pin.ready), .in_final(pin.final_point),
    .out_valid(pout.valid), .out_ready(pout.ready), .out_index(pout.sample_index),
    .out_last(pout.final_sample), .out_dropped(pout.points_dropped),
    .sample_count, .cmd, .stat, .fill, .term, .order, .t_sample, .span
  );

  bcs_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .fill, .term, .order, .sample(t_sample), .span,
    .in_x(pin.point_x), .in_y(pin.point_y), .in_z(pin.point_z),
    .res_x(pout.curve_x), .res_y(pout.curve_y), .res_z(pout.curve_z)
  );

endmodule
